>>> rtl/core/sac_pkg.sv
`timescale 1ns / 1ps

package sac_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned SETS        = 64;
  localparam int unsigned WAYS        = 4;
  localparam int unsigned BLOCK_BYTES = 64;

  localparam int unsigned OFF_W   = $clog2(BLOCK_BYTES);
  localparam int unsigned SET_LOG = $clog2(SETS);
  localparam int unsigned SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned TAG_W   = ADDR_W - OFF_W - SET_LOG;
  localparam int unsigned WAY_OUT_W = 2;
  localparam int unsigned CNT_W   = 32;

  localparam logic [SET_W-1:0] SET_MASK = SET_W'(SETS - 1);
  localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [SET_W-1:0] set_t;
  typedef logic [WAY_W-1:0] way_t;

  function automatic set_t set_of(input logic [ADDR_W-1:0] addr);
    set_of = SET_W'(addr >> OFF_W) & SET_MASK;
  endfunction

  function automatic tag_t tag_of(input logic [ADDR_W-1:0] addr);
    tag_of = TAG_W'(addr >> (OFF_W + SET_LOG));
  endfunction

  function automatic way_t next_way(input way_t way);
    next_way = (way == LAST_WAY) ? '0 : way + WAY_W'(1);
  endfunction

  function automatic logic [WAY_OUT_W-1:0] way_field(input way_t way);
    logic [WAY_W+WAY_OUT_W-1:0] ext;
    ext = {{WAY_OUT_W{1'b0}}, way};
    way_field = ext[WAY_OUT_W-1:0];
  endfunction

endpackage

>>> rtl/core/sac_ram.sv
`timescale 1ns / 1ps

module sac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read returns the old contents on a same-cycle write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/set_assoc_cache_tag_fifo.sv
`timescale 1ns / 1ps
// channel  dir  handshake              fields
// in       in   in_valid_i/in_stall_o   read_address_i
// out      out  out_valid_o/out_stall_i hit_o way_used_o miss_count_o request_count_o
//
// one beat per cycle unless the result side stalls; a result passes the lookup stage, then the result register
// tag and fill pointer ram reads are issued at input accept, compared in the
// next cycle; a miss writing the same set at the edge that issues the read is forwarded
// reset clears valid bits, counters and handshake state; no clearing pass
// a stalled result holds the lookup stage, which then stalls the input

module set_assoc_cache_tag_fifo (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] read_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic [1:0]  way_used_o,
  output logic [31:0] miss_count_o,
  output logic [31:0] request_count_o
);

  logic                accept_in;
  logic                commit;
  logic                do_fill;

  logic                s1_valid_q, s1_valid_d;
  sac_pkg::tag_t       s1_tag_q;
  sac_pkg::set_t       s1_set_q;

  logic [sac_pkg::WAYS-1:0] valid_q [sac_pkg::SETS];

  sac_pkg::tag_t       tag_rd [sac_pkg::WAYS];
  sac_pkg::way_t       ptr_rd;

  logic                fwd_valid_q;
  sac_pkg::set_t       fwd_set_q;
  sac_pkg::way_t       fwd_way_q;
  sac_pkg::tag_t       fwd_tag_q;
  sac_pkg::way_t       fwd_ptr_q;
  logic                fwd_same;

  logic [sac_pkg::WAYS-1:0] set_valid;
  logic [sac_pkg::WAYS-1:0] match;
  logic                hit;
  sac_pkg::way_t       hit_way;
  sac_pkg::way_t       ptr_cur;
  sac_pkg::way_t       ptr_next;
  sac_pkg::way_t       way_sel;

  logic [sac_pkg::CNT_W-1:0] req_q, req_d;
  logic [sac_pkg::CNT_W-1:0] miss_q, miss_d;

  logic                out_valid_q;
  logic                out_hit_q;
  logic [1:0]          out_way_q;
  logic [31:0]         out_miss_q;
  logic [31:0]         out_req_q;

  assign commit     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !commit;
  assign accept_in  = in_valid_i && !in_stall_o;
  assign do_fill    = commit && !hit;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept_in) begin
      s1_valid_d = 1'b1;
    end else if (commit) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      s1_tag_q <= sac_pkg::tag_of(read_address_i);
      s1_set_q <= sac_pkg::set_of(read_address_i);
    end
  end

  for (genvar w = 0; w < sac_pkg::WAYS; w++) begin : g_way
    sac_ram #(
      .WIDTH (sac_pkg::TAG_W),
      .DEPTH (sac_pkg::SETS)
    ) u_tag_ram (
      .clk_i   (clk_i),
      .we_i    (do_fill && (ptr_cur == sac_pkg::WAY_W'(w))),
      .waddr_i (s1_set_q),
      .wdata_i (s1_tag_q),
      .re_i    (accept_in),
      .raddr_i (sac_pkg::set_of(read_address_i)),
      .rdata_o (tag_rd[w])
    );
  end

  sac_ram #(
    .WIDTH (sac_pkg::WAY_W),
    .DEPTH (sac_pkg::SETS)
  ) u_ptr_ram (
    .clk_i   (clk_i),
    .we_i    (do_fill),
    .waddr_i (s1_set_q),
    .wdata_i (ptr_next),
    .re_i    (accept_in),
    .raddr_i (sac_pkg::set_of(read_address_i)),
    .rdata_o (ptr_rd)
  );

  // fill committed at the edge this item's ram read was issued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (accept_in) begin
      fwd_valid_q <= do_fill;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      fwd_set_q <= s1_set_q;
      fwd_way_q <= ptr_cur;
      fwd_tag_q <= s1_tag_q;
      fwd_ptr_q <= ptr_next;
    end
  end

  assign fwd_same  = fwd_valid_q && (fwd_set_q == s1_set_q);
  assign set_valid = valid_q[s1_set_q];

  always_comb begin
    sac_pkg::tag_t t;
    match   = '0;
    hit_way = '0;
    for (int w = 0; w < sac_pkg::WAYS; w++) begin
      t = (fwd_same && (fwd_way_q == sac_pkg::WAY_W'(w))) ? fwd_tag_q : tag_rd[w];
      match[w] = set_valid[w] && (t == s1_tag_q);
    end
    for (int w = sac_pkg::WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = sac_pkg::WAY_W'(w);
      end
    end
  end

  assign hit      = |match;
  // an empty set has never had its pointer written
  assign ptr_cur  = fwd_same ? fwd_ptr_q : ((|set_valid) ? ptr_rd : '0);
  assign ptr_next = sac_pkg::next_way(ptr_cur);
  assign way_sel  = hit ? hit_way : ptr_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < sac_pkg::SETS; s++) begin
        valid_q[s] <= '0;
      end
    end else if (do_fill) begin
      valid_q[s1_set_q][ptr_cur] <= 1'b1;
    end
  end

  assign req_d  = req_q + sac_pkg::CNT_W'(1);
  assign miss_d = hit ? miss_q : miss_q + sac_pkg::CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q       <= '0;
      miss_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        req_q  <= req_d;
        miss_q <= miss_d;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_hit_q  <= hit;
      out_way_q  <= sac_pkg::way_field(way_sel);
      out_miss_q <= miss_d;
      out_req_q  <= req_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign way_used_o      = out_way_q;
  assign miss_count_o    = out_miss_q;
  assign request_count_o = out_req_q;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty lookup stage");

  a_hit_keeps_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && hit) |=> (miss_q == $past(miss_q)))
    else $error("miss counter moved on a hit");

  a_req_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (req_q == $past(req_q) + 32'd1) && out_valid_q)
    else $error("request counter or result register out of step");

endmodule

>>> tb/set_assoc_cache_tag_fifo_checker.sv
`timescale 1ns / 1ps

module set_assoc_cache_tag_fifo_checker
  import sac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] read_address_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        hit_i,
  input  logic [1:0]  way_used_i,
  input  logic [31:0] miss_count_i,
  input  logic [31:0] request_count_i,
  output int          mismatches_o,
  output int          outstanding_o
);

  typedef struct packed {
    logic        hit;
    logic [1:0]  way;
    logic [31:0] misses;
    logic [31:0] requests;
  } lookup_result_t;

  lookup_result_t lookup_q[$];

  tag_t        tag_mem [SETS][WAYS];
  logic        line_valid [SETS][WAYS];
  int unsigned fill_ptr [SETS];
  logic [31:0] miss_total;
  logic [31:0] request_total;
  int          mismatch_total;

  function automatic lookup_result_t lookup_and_fill(input logic [31:0] addr);
    int unsigned    set_idx;
    tag_t           tag;
    int unsigned    way;
    logic           found;
    lookup_result_t res;
    set_idx = (addr >> OFF_W) % SETS;
    tag = tag_t'(addr >> (OFF_W + SET_LOG));
    found = 1'b0;
    way = 0;
    request_total = request_total + 32'd1;
    // descending scan so the lowest matching way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (line_valid[set_idx][w] && tag_mem[set_idx][w] == tag) begin
        found = 1'b1;
        way = w;
      end
    end
    if (!found) begin
      miss_total = miss_total + 32'd1;
      way = fill_ptr[set_idx];
      tag_mem[set_idx][way] = tag;
      line_valid[set_idx][way] = 1'b1;
      fill_ptr[set_idx] = (way + 1 == WAYS) ? 0 : way + 1;
    end
    res.hit = found;
    res.way = 2'(way);
    res.misses = miss_total;
    res.requests = request_total;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t exp_r;
    if (!rst_ni) begin
      for (int s = 0; s < SETS; s++) begin
        fill_ptr[s] = 0;
        for (int w = 0; w < WAYS; w++) begin
          line_valid[s][w] = 1'b0;
        end
      end
      miss_total = '0;
      request_total = '0;
      mismatch_total = 0;
      lookup_q.delete();
      mismatches_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (lookup_q.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display("unexpected result beat: hit=%0b way=%0d misses=%0d requests=%0d",
                     hit_i, way_used_i, miss_count_i, request_count_i);
        end else begin
          exp_r = lookup_q.pop_front();
          if (hit_i !== exp_r.hit || way_used_i !== exp_r.way ||
              miss_count_i !== exp_r.misses || request_count_i !== exp_r.requests) begin
            mismatch_total++;
            if (mismatch_total <= 10)
              $display("result mismatch: exp hit=%0b way=%0d misses=%0d requests=%0d, %s",
                       exp_r.hit, exp_r.way, exp_r.misses, exp_r.requests,
                       $sformatf("got hit=%0b way=%0d misses=%0d requests=%0d",
                                 hit_i, way_used_i, miss_count_i, request_count_i));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        lookup_q.push_back(lookup_and_fill(read_address_i));
      end
      mismatches_o <= mismatch_total;
      outstanding_o <= lookup_q.size();
    end
  end

endmodule

>>> tb/tb_set_assoc_cache_tag_fifo.sv
`timescale 1ns / 1ps

module tb_set_assoc_cache_tag_fifo;
  import sac_pkg::*;

  localparam int unsigned RANDOM_READS = 450;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] read_address_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        hit_o;
  logic [1:0]  way_used_o;
  logic [31:0] miss_count_o;
  logic [31:0] request_count_o;

  int          mismatches;
  int          outstanding;
  int unsigned cycle_count;
  logic        calm;
  int unsigned stall_run;

  set_assoc_cache_tag_fifo dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .read_address_i (read_address_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .way_used_o     (way_used_o),
    .miss_count_o   (miss_count_o),
    .request_count_o(request_count_o)
  );

  set_assoc_cache_tag_fifo_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .read_address_i (read_address_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_i          (hit_o),
    .way_used_i     (way_used_o),
    .miss_count_i   (miss_count_o),
    .request_count_i(request_count_o),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    int unsigned r;
    out_stall_i = 1'b0;
    stall_run = 0;
    forever begin
      @(negedge clk_i);
      if (stall_run != 0) begin
        out_stall_i <= 1'b1;
        stall_run--;
      end else begin
        r = $urandom_range(0, 99);
        if (!calm && r < 3) stall_run = $urandom_range(5, 30);
        out_stall_i <= !calm && r < 30;
      end
    end
  end

  function automatic logic [31:0] make_addr(input logic [31:0] tag, input int unsigned set_idx,
                                            input int unsigned offset);
    return (tag << (OFF_W + SET_LOG)) | (32'(set_idx % SETS) << OFF_W) |
           32'(offset % BLOCK_BYTES);
  endfunction

  task automatic send_read(input logic [31:0] addr);
    int unsigned r;
    int unsigned gap;
    r = $urandom_range(0, 99);
    if (calm || r < 70) gap = 0;
    else if (r < 93) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    read_address_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin
    logic [31:0] tag_pool [6];
    int unsigned hot_sets [4];
    logic [31:0] last_addr;
    logic [31:0] addr;
    int unsigned r;
    cycle_count = 0;
    calm = 1'b1;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    read_address_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, set fill with wrap, hits in several ways, same-set back to back
    send_read(32'h0000_0000);
    send_read(32'h0000_003F);
    send_read(32'hFFFF_FFFF);
    send_read(32'hFFFF_FFC0);
    send_read(make_addr(1, 0, 0));
    send_read(make_addr(2, 0, 5));
    send_read(make_addr(3, 0, 63));
    send_read(make_addr(4, 0, 0));
    send_read(make_addr(0, 0, 0));
    send_read(make_addr(3, 0, 1));
    send_read(make_addr(4, 0, 2));
    send_read(make_addr(2, 0, 3));
    send_read(make_addr(5, 1, 0));
    send_read(make_addr(5, 1, 9));
    send_read(make_addr(32'hF_FFFF, 0, 0));
    send_read(make_addr(32'hF_FFFF, 63, 0));
    send_read(make_addr(32'hA_AAAA, 21, 32));
    send_read(make_addr(32'h5_5555, 42, 31));
    send_read(make_addr(32'hA_AAAA, 21, 0));
    calm = 1'b0;

    last_addr = '0;
    for (int unsigned i = 0; i < RANDOM_READS; i++) begin
      if (i % 100 == 0) begin
        foreach (tag_pool[j]) tag_pool[j] = $urandom & ((32'd1 << TAG_W) - 1);
        foreach (hot_sets[j]) hot_sets[j] = $urandom_range(0, SETS - 1);
      end
      if (i % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 80)
        addr = make_addr(tag_pool[$urandom_range(0, 5)], hot_sets[$urandom_range(0, 3)],
                         $urandom_range(0, BLOCK_BYTES - 1));
      else if (r < 90)
        addr = last_addr;
      else
        addr = $urandom;
      send_read(addr);
      last_addr = addr;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    calm = 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
